[hdl/ple_pkg.sv]
`timescale 1ns / 1ps

package ple_pkg;

    // Operation codes carried in the op field of a request
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_LOCATE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Fixed field widths of the request and response transactions
    localparam int POS_FIELD_W  = 5;
    localparam int WORD_FIELD_W = 32;

    typedef struct packed {
        logic [2:0]                     op;
        logic [POS_FIELD_W-1:0]         position;
        logic signed [WORD_FIELD_W-1:0] value;
    } ple_req_t;

    typedef struct packed {
        logic                           ok;
        logic signed [WORD_FIELD_W-1:0] read_value;
        logic [POS_FIELD_W-1:0]         found_position;
        logic [POS_FIELD_W-1:0]         length;
    } ple_rsp_t;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic ins;     // shift up behind the position, load the value at it
        logic del;     // shift down from the position onwards
        logic wr;      // overwrite the entry at the position
        logic rd;      // drop the entry at the position onto the scan bus
        logic locate;  // mark the first live entry equal to the value
    } ple_ctrl_t;

endpackage

[hdl/ple_cell.sv]
`timescale 1ns / 1ps

module ple_cell #(
    parameter int INDEX      = 0,
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ple_pkg::ple_ctrl_t                            ctrl,
    input  logic [((($clog2(CAPACITY+1)) > ple_pkg::POS_FIELD_W) ?
                   $clog2(CAPACITY+1) : ple_pkg::POS_FIELD_W)-1:0] pos,
    input  logic signed [DATA_WIDTH-1:0]                  value,
    input  logic [$clog2(CAPACITY+1)-1:0]                 count,
    input  logic signed [DATA_WIDTH-1:0]                  left_entry,
    input  logic signed [DATA_WIDTH-1:0]                  right_entry,
    output logic signed [DATA_WIDTH-1:0]                  entry,
    input  logic                                          scan_in_valid,
    input  logic signed [DATA_WIDTH-1:0]                  scan_in_data,
    input  logic [$clog2(CAPACITY+1)-1:0]                 scan_in_found,
    output logic                                          scan_out_valid,
    output logic signed [DATA_WIDTH-1:0]                  scan_out_data,
    output logic [$clog2(CAPACITY+1)-1:0]                 scan_out_found
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > ple_pkg::POS_FIELD_W) ? CNT_W : ple_pkg::POS_FIELD_W;

    logic signed [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic                         scan_valid_reg, scan_valid_next;
    logic signed [DATA_WIDTH-1:0] scan_data_reg, scan_data_next;
    logic [CNT_W-1:0]             scan_found_reg, scan_found_next;
    logic                         at_pos;
    logic                         past_pos;
    logic                         in_list;

    // This cell sits at 1-based position INDEX+1
    assign at_pos   = (pos == POS_W'(INDEX + 1));
    assign past_pos = (POS_W'(INDEX + 1) > pos);
    assign in_list  = (CNT_W'(INDEX) < count);

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.ins)
        begin
            if (at_pos)
                entry_next = value;
            else if (past_pos)
                entry_next = left_entry;
        end
        else if (ctrl.del)
        begin
            if (at_pos || past_pos)
                entry_next = right_entry;
        end
        else if (ctrl.wr && at_pos)
        begin
            entry_next = value;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_comb
    begin
        scan_valid_next = scan_in_valid;
        scan_data_next  = scan_in_data;
        scan_found_next = scan_in_found;
        if (ctrl.rd && at_pos && in_list)
            scan_data_next = scan_in_data | entry_reg;
        if (ctrl.locate && in_list && (scan_in_found == '0) && (entry_reg == value))
            scan_found_next = CNT_W'(INDEX + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_valid_reg <= 1'b0;
        else
            scan_valid_reg <= scan_valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        scan_data_reg  <= scan_data_next;
        scan_found_reg <= scan_found_next;
    end

    assign entry          = entry_reg;
    assign scan_out_valid = scan_valid_reg;
    assign scan_out_data  = scan_data_reg;
    assign scan_out_found = scan_found_reg;

endmodule

[hdl/positional_list_engine.sv]
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed words, addressed by 1-based position,
// held in a row of cells. One request transaction is taken at a time. The
// request is latched, then executed on the following cycle: insert, delete,
// write and clear (and unknown codes) finish there. Insert and delete move
// every cell behind the position to its neighbour in that execute step. Read
// and locate send a scan token down the row of cells, one cell per cycle, and
// respond when the token leaves the last cell. A finished response waits in
// the output register (with one skid slot behind it), so a new request is
// taken while a response is still waiting for rsp_ready, as long as the skid
// slot is empty. Stored words keep their low DATA_WIDTH bits; read_value is
// sign-extended from DATA_WIDTH. Entries have no reset value.

module positional_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ple_pkg::ple_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ple_pkg::ple_rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > ple_pkg::POS_FIELD_W) ? CNT_W : ple_pkg::POS_FIELD_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]            state_reg, state_next;
    ple_pkg::ple_req_t     cmd_reg, cmd_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    ple_pkg::ple_rsp_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    ple_pkg::ple_rsp_t     skid_reg, skid_next;
    logic                  skid_valid_reg, skid_valid_next;

    ple_pkg::ple_rsp_t     res;
    logic                  res_valid;
    ple_pkg::ple_ctrl_t    ctrl;
    logic                  req_take;
    logic                  out_free;
    logic [POS_W-1:0]      pos_ext;
    logic [POS_W-1:0]      count_ext;
    logic                  pos_in_list;
    logic                  pos_insertable;
    logic                  is_scan_op;
    logic signed [DATA_WIDTH-1:0] cmd_word;

    // Row of cells and the links between neighbours
    logic signed [DATA_WIDTH-1:0] entry_w   [CAPACITY];
    logic                         scan_v    [CAPACITY+1];
    logic signed [DATA_WIDTH-1:0] scan_d    [CAPACITY+1];
    logic [CNT_W-1:0]             scan_f    [CAPACITY+1];

    assign req_take  = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE) && !skid_valid_reg;

    assign pos_ext        = POS_W'(cmd_reg.position);
    assign count_ext      = POS_W'(count_reg);
    // Position valid for delete, read and write: 1 to length
    assign pos_in_list    = (pos_ext != '0) && (pos_ext <= count_ext);
    // Position valid for insert: 1 to length+1, and room left
    assign pos_insertable = (pos_ext != '0) && ((pos_ext - POS_W'(1)) <= count_ext)
                            && (count_reg < CNT_W'(CAPACITY));
    assign is_scan_op     = (cmd_reg.op == ple_pkg::OP_READ) ||
                            (cmd_reg.op == ple_pkg::OP_LOCATE);
    assign cmd_word       = DATA_WIDTH'(cmd_reg.value);

    // Broadcast controls; read and locate stay up for the whole scan
    always_comb
    begin
        ctrl        = '0;
        ctrl.rd     = (cmd_reg.op == ple_pkg::OP_READ);
        ctrl.locate = (cmd_reg.op == ple_pkg::OP_LOCATE);
        if (state_reg == ST_EXEC)
        begin
            ctrl.ins = (cmd_reg.op == ple_pkg::OP_INSERT) && pos_insertable;
            ctrl.del = (cmd_reg.op == ple_pkg::OP_DELETE) && pos_in_list;
            ctrl.wr  = (cmd_reg.op == ple_pkg::OP_WRITE)  && pos_in_list;
        end
    end

    // Launch the scan token into the first cell
    assign scan_v[0] = (state_reg == ST_EXEC) && is_scan_op;
    assign scan_d[0] = '0;
    assign scan_f[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_w;
        logic signed [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cmd_word;
        end
        else
        begin : g_inner_left
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = entry_w[i];
        end
        else
        begin : g_inner_right
            assign right_w = entry_w[i+1];
        end

        ple_cell #(
            .INDEX      (i),
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .pos            (pos_ext),
            .value          (cmd_word),
            .count          (count_reg),
            .left_entry     (left_w),
            .right_entry    (right_w),
            .entry          (entry_w[i]),
            .scan_in_valid  (scan_v[i]),
            .scan_in_data   (scan_d[i]),
            .scan_in_found  (scan_f[i]),
            .scan_out_valid (scan_v[i+1]),
            .scan_out_data  (scan_d[i+1]),
            .scan_out_found (scan_f[i+1])
        );
    end

    // Sequencer: latch, execute, and wait for the scan token where needed
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.length = ple_pkg::POS_FIELD_W'(count_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    cmd_next   = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_scan_op)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    unique case (cmd_reg.op)
                        ple_pkg::OP_INSERT:
                        begin
                            res.ok = pos_insertable;
                            if (pos_insertable)
                                count_next = count_reg + CNT_W'(1);
                        end
                        ple_pkg::OP_DELETE:
                        begin
                            res.ok = pos_in_list;
                            if (pos_in_list)
                                count_next = count_reg - CNT_W'(1);
                        end
                        ple_pkg::OP_WRITE:
                        begin
                            res.ok = pos_in_list;
                        end
                        ple_pkg::OP_CLEAR:
                        begin
                            res.ok     = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            res.ok = 1'b0;
                        end
                    endcase
                    res.length = ple_pkg::POS_FIELD_W'(count_next);
                end
            end
            ST_SCAN:
            begin
                if (scan_v[CAPACITY])
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    if (cmd_reg.op == ple_pkg::OP_READ)
                    begin
                        res.ok         = pos_in_list;
                        res.read_value = ple_pkg::WORD_FIELD_W'(scan_d[CAPACITY]);
                    end
                    else
                    begin
                        res.ok             = 1'b1;
                        res.found_position = ple_pkg::POS_FIELD_W'(scan_f[CAPACITY]);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register with one skid slot; a response is only produced while
    // the skid slot is empty
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || res_valid;
            out_next        = skid_valid_reg ? skid_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // A fresh response never meets an occupied skid slot
    a_skid_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(skid_valid_reg && res_valid))
        else $error("response produced while skid slot occupied");

    // Length never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    // A taken request is executed on the next cycle
    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg == ST_EXEC))
        else $error("request not executed after acceptance");

    // The scan token only leaves the row while waiting for it
    a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_v[CAPACITY] |-> (state_reg == ST_SCAN))
        else $error("scan token arrived outside scan state");

endmodule

[tb/sv/list_result_checker.sv]
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  ple_pkg::ple_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ple_pkg::ple_rsp_t rsp,
    output int                mismatches,
    output int                outstanding
);

    // Mirror of the list: cells beyond fill hold stale words and are never read
    logic [ple_pkg::WORD_FIELD_W-1:0] cells [CAPACITY];
    int fill = 0;
    ple_pkg::ple_rsp_t pending_results[$];
    ple_pkg::ple_rsp_t want;

    function automatic ple_pkg::ple_rsp_t apply_list_op(input ple_pkg::ple_req_t r);
        ple_pkg::ple_rsp_t res;
        int pos;
        res = '0;
        pos = int'(r.position);
        case (r.op)
            ple_pkg::OP_INSERT:
                if (pos >= 1 && pos <= fill + 1 && fill < CAPACITY)
                begin
                    for (int i = fill; i >= pos; i--)
                        cells[i] = cells[i-1];
                    cells[pos-1] = r.value;
                    fill++;
                    res.ok = 1'b1;
                end
            ple_pkg::OP_DELETE:
                if (pos >= 1 && pos <= fill)
                begin
                    for (int i = pos; i < fill; i++)
                        cells[i-1] = cells[i];
                    fill--;
                    res.ok = 1'b1;
                end
            ple_pkg::OP_READ:
                if (pos >= 1 && pos <= fill)
                begin
                    res.read_value = cells[pos-1];
                    res.ok = 1'b1;
                end
            ple_pkg::OP_WRITE:
                if (pos >= 1 && pos <= fill)
                begin
                    cells[pos-1] = r.value;
                    res.ok = 1'b1;
                end
            ple_pkg::OP_LOCATE:
            begin
                // first match wins
                for (int i = 0; i < fill; i++)
                    if (res.found_position == '0 && cells[i] == r.value)
                        res.found_position = 5'(i + 1);
                res.ok = 1'b1;
            end
            ple_pkg::OP_CLEAR:
            begin
                fill = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.length = 5'(fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            mismatches = 0;
            pending_results.delete();
        end
        else
        begin
            // retire before predicting: a response never belongs to a same-edge request
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: ok=%0b read_value=%0d found=%0d length=%0d",
                                 rsp.ok, rsp.read_value, rsp.found_position, rsp.length);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.ok !== want.ok || rsp.read_value !== want.read_value ||
                        rsp.found_position !== want.found_position ||
                        rsp.length !== want.length)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"response mismatch: expected ok=%0b read_value=%0d ",
                                      "found=%0d length=%0d, got ok=%0b read_value=%0d ",
                                      "found=%0d length=%0d"},
                                     want.ok, want.read_value, want.found_position,
                                     want.length, rsp.ok, rsp.read_value,
                                     rsp.found_position, rsp.length);
                    end
                end
            end
            if (req_valid && req_ready)
                pending_results.push_back(apply_list_op(req));
        end
        outstanding = pending_results.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY        = 16;
    localparam int CYCLE_LIMIT     = 400000;
    // margin of idle clocks after the drain, scaled by the length of the cell row
    localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;
    localparam int ITEMS_PER_PHASE = 385;

    // codes the block must ignore
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // op mix of one stretch of random transactions
    typedef enum {GROW, SHRINK, MIXED} mix_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    ple_pkg::ple_req_t req;
    logic              rsp_valid;
    logic              rsp_ready;
    ple_pkg::ple_rsp_t rsp;

    int mismatches;
    int outstanding;
    int idle_pct;
    int stall_pct;
    int list_len;     // length seen by the stimulus, used only to aim positions
    int cycles = 0;

    logic signed [ple_pkg::WORD_FIELD_W-1:0] word_pool [8];

    positional_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (ple_pkg::WORD_FIELD_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    list_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: stall at random at the rate of the current phase
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one request transaction. Idle first at the sender's rate, then hold
    // valid and the payload until the block accepts. Valid is left high on
    // return so that a back-to-back transaction never drops it within a step.
    task automatic issue(input logic [2:0] op, input logic [4:0] pos,
                         input logic signed [ple_pkg::WORD_FIELD_W-1:0] val);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{op: op, position: pos, value: val};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        // track the length so that positions can be aimed at the live range
        case (op)
            ple_pkg::OP_INSERT:
                if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY)
                    list_len++;
            ple_pkg::OP_DELETE:
                if (pos >= 1 && pos <= list_len)
                    list_len--;
            ple_pkg::OP_CLEAR:
                list_len = 0;
            default: ;
        endcase
    endtask

    // Words from a small pool at the given rate, so that duplicates and locate hits are common
    function automatic logic signed [ple_pkg::WORD_FIELD_W-1:0] pick_word(input int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return word_pool[3'($urandom_range(7))];
        return $urandom;
    endfunction

    // Mostly a position inside the live range, otherwise anything the field holds
    function automatic logic [4:0] pick_position(input logic [2:0] op);
        int top;
        top = (op == ple_pkg::OP_INSERT) ? list_len + 1 : list_len;
        if (top < 1)
            top = 1;
        if ($urandom_range(99) < 85)
            return 5'($urandom_range(top, 1));
        return 5'($urandom_range(31));
    endfunction

    // Random transactions in stretches of forty, each stretch biased to grow
    // the list towards full, shrink it towards empty, or hold it about level
    task automatic random_phase(input int n_items);
        mix_t       mix;
        int         r;
        int         ins_w;
        logic [2:0] op;
        mix = MIXED;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
                mix = mix_t'($urandom_range(2));
            ins_w = (mix == GROW) ? 46 : (mix == SHRINK) ? 12 : 30;
            r = $urandom_range(99);
            if (r < ins_w)
                op = ple_pkg::OP_INSERT;
            else if (r < 56)
                op = ple_pkg::OP_DELETE;
            else if (r < 71)
                op = ple_pkg::OP_READ;
            else if (r < 81)
                op = ple_pkg::OP_WRITE;
            else if (r < 96)
                op = ple_pkg::OP_LOCATE;
            else if (r < 98)
                op = ple_pkg::OP_CLEAR;
            else
                op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
            issue(op, pick_position(op), pick_word(op == ple_pkg::OP_LOCATE ? 70 : 50));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        idle_pct  = 0;
        stall_pct = 0;
        list_len  = 0;
        word_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list failures, ends of the insert range, extreme
        // words, each op, out-of-range positions and the ignored codes
        issue(ple_pkg::OP_INSERT, 5'd0,  32'sd5);
        issue(ple_pkg::OP_READ,   5'd1,  32'sd0);
        issue(ple_pkg::OP_DELETE, 5'd1,  32'sd0);
        issue(ple_pkg::OP_LOCATE, 5'd0,  32'sd0);
        issue(ple_pkg::OP_INSERT, 5'd1,  32'h7FFF_FFFF);
        issue(ple_pkg::OP_INSERT, 5'd1,  32'h8000_0000);
        issue(ple_pkg::OP_INSERT, 5'd3,  32'sd0);
        issue(ple_pkg::OP_INSERT, 5'd5,  32'sd9);
        issue(ple_pkg::OP_READ,   5'd1,  32'sd0);
        issue(ple_pkg::OP_READ,   5'd3,  32'sd0);
        issue(ple_pkg::OP_READ,   5'd4,  32'sd0);
        issue(ple_pkg::OP_WRITE,  5'd2,  32'hFFFF_FFFF);
        issue(ple_pkg::OP_WRITE,  5'd0,  32'sd7);
        issue(ple_pkg::OP_LOCATE, 5'd31, 32'hFFFF_FFFF);
        issue(ple_pkg::OP_LOCATE, 5'd1,  32'sd12345);
        issue(ple_pkg::OP_DELETE, 5'd2,  32'sd0);
        issue(ple_pkg::OP_DELETE, 5'd31, 32'sd0);
        issue(OP_SPARE_LO, 5'd1, 32'hFFFF_FFFF);
        issue(OP_SPARE_HI, 5'd31, 32'h8000_0000);
        issue(ple_pkg::OP_CLEAR,  5'd31, 32'hFFFF_FFFF);

        // Random: no idling, sender idling, receiver stalling, then both
        random_phase(ITEMS_PER_PHASE);
        idle_pct = 47;
        random_phase(ITEMS_PER_PHASE);
        idle_pct  = 0;
        stall_pct = 47;
        random_phase(ITEMS_PER_PHASE);
        idle_pct  = 23;
        stall_pct = 23;
        random_phase(ITEMS_PER_PHASE);

        // Drop valid on the edge of the last acceptance, then drain
        stall_pct = 0;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
